// ===== hw/rtl/mahd_pkg.sv =====
// ----------------------------------------------------------------------------
// mahd_pkg
// Shared types, field codes and lookup tables for the audio frame header
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mahd_pkg;

    // Header layout codes
    localparam logic [31:0] SYNC_MASK  = 32'hFFE0_0000;

    localparam logic [1:0]  VER_V25    = 2'd0;
    localparam logic [1:0]  VER_RSVD   = 2'd1;
    localparam logic [1:0]  VER_V2     = 2'd2;
    localparam logic [1:0]  VER_V1     = 2'd3;

    localparam logic [1:0]  LAYER_RSVD = 2'd0;
    localparam logic [1:0]  LAYER_III  = 2'd1;
    localparam logic [1:0]  LAYER_II   = 2'd2;
    localparam logic [1:0]  LAYER_I    = 2'd3;

    localparam logic [3:0]  BIDX_FREE  = 4'd0;
    localparam logic [3:0]  BIDX_BAD   = 4'd15;
    localparam logic [1:0]  SIDX_RSVD  = 2'd3;
    localparam logic [1:0]  MODE_MONO  = 2'd3;

    // Widths
    localparam int NUM_W   = 27;           // coefficient * kbps << version shift
    localparam int RECIP_W = 18;           // floor(2^32 / base rate)
    localparam int RECIP_S = 32;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QUOT_W  = PROD_W - RECIP_S;
    localparam int RATE_W  = 16;
    localparam int KBPS_W  = 9;
    localparam int SPF_W   = 11;
    localparam int CHAN_W  = 2;
    localparam int BYTES_W = 12;
    localparam int COEF_W  = 18;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Frame length coefficients
    localparam logic [COEF_W-1:0] COEF_L1   = COEF_W'(12000);
    localparam logic [COEF_W-1:0] COEF_FULL = COEF_W'(144000);
    localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(72000);

    localparam logic [SPF_W-1:0] SPF_L1   = SPF_W'(384);
    localparam logic [SPF_W-1:0] SPF_HALF = SPF_W'(576);
    localparam logic [SPF_W-1:0] SPF_FULL = SPF_W'(1152);

    // Base sampling rates by sampling index; the reserved slot is never used
    localparam logic [RATE_W-1:0] RATE_BASE [4] = '{
        RATE_W'(44100), RATE_W'(48000), RATE_W'(32000), RATE_W'(44100)
    };

    localparam logic [RECIP_W-1:0] RECIP_TAB [4] = '{
        RECIP_W'((64'd1 << RECIP_S) / 64'd44100),
        RECIP_W'((64'd1 << RECIP_S) / 64'd48000),
        RECIP_W'((64'd1 << RECIP_S) / 64'd32000),
        RECIP_W'((64'd1 << RECIP_S) / 64'd44100)
    };

    // Bitrate tables indexed by the raw bitrate index (free and bad read 0)
    localparam logic [KBPS_W-1:0] KBPS_L1_V1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_L1_V2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_L2_V1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_L3_V1 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_L23_V2 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };

    // One classified header on its way from the front end to the divider
    typedef struct packed {
        logic              ok;
        logic [NUM_W-1:0]  num;
        logic [1:0]        sidx;
        logic              pad;
        logic              layer1;
        logic [RATE_W-1:0] rate;
        logic [CHAN_W-1:0] chans;
        logic [KBPS_W-1:0] kbps;
        logic [SPF_W-1:0]  spf;
    } mahd_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mahd_front.sv =====
// ----------------------------------------------------------------------------
// mahd_front
// Accepts header requests, validates them, looks up rates and forms the
// frame length numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_front
    import mahd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] header_word,
    input  wire logic        q_full,
    output logic             q_push,
    output mahd_item_t       q_item
);

    logic       front_valid_reg;
    logic       front_valid_next;
    mahd_item_t front_item_reg;
    mahd_item_t item_next;
    logic       take;

    logic [1:0]        ver;
    logic [1:0]        lay;
    logic [3:0]        bidx;
    logic [1:0]        sidx;
    logic              ok;
    logic [RATE_W-1:0] base;
    logic [RATE_W-1:0] rate;
    logic [KBPS_W-1:0] kbps;
    logic [COEF_W-1:0] coef;
    logic [SPF_W-1:0]  spf;
    logic [NUM_W-1:0]  kprod;
    logic [NUM_W-1:0]  num;

    assign ver  = header_word[20:19];
    assign lay  = header_word[18:17];
    assign bidx = header_word[15:12];
    assign sidx = header_word[11:10];

    assign ok = ((header_word & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSVD)
             && (lay != LAYER_RSVD) && (bidx != BIDX_FREE) && (bidx != BIDX_BAD)
             && (sidx != SIDX_RSVD);

    assign base = RATE_BASE[sidx];

    always_comb
    begin
        unique case (ver)
            VER_V1:  rate = base;
            VER_V2:  rate = base >> 1;
            default: rate = base >> 2;
        endcase
    end

    always_comb
    begin
        priority if (lay == LAYER_I)
        begin
            kbps = (ver == VER_V1) ? KBPS_L1_V1[bidx] : KBPS_L1_V2[bidx];
            coef = COEF_L1;
            spf  = SPF_L1;
        end
        else if (ver == VER_V1)
        begin
            kbps = (lay == LAYER_II) ? KBPS_L2_V1[bidx] : KBPS_L3_V1[bidx];
            coef = COEF_FULL;
            spf  = SPF_FULL;
        end
        else if (lay == LAYER_III)
        begin
            kbps = KBPS_L23_V2[bidx];
            coef = COEF_HALF;
            spf  = SPF_HALF;
        end
        else
        begin
            kbps = KBPS_L23_V2[bidx];
            coef = COEF_FULL;
            spf  = SPF_FULL;
        end
    end

    // Dividing by a halved or quartered rate is the same as scaling the numerator
    assign kprod = NUM_W'(coef) * NUM_W'(kbps);

    always_comb
    begin
        unique case (ver)
            VER_V1:  num = kprod;
            VER_V2:  num = kprod << 1;
            default: num = kprod << 2;
        endcase
    end

    always_comb
    begin
        item_next        = '0;
        item_next.spf    = SPF_FULL;
        if (ok)
        begin
            item_next.ok     = 1'b1;
            item_next.num    = num;
            item_next.sidx   = sidx;
            item_next.pad    = header_word[9];
            item_next.layer1 = (lay == LAYER_I);
            item_next.rate   = rate;
            item_next.chans  = (header_word[7:6] == MODE_MONO) ? CHAN_W'(1) : CHAN_W'(2);
            item_next.kbps   = kbps;
            item_next.spf    = spf;
        end
    end

    // Hold the classified request until the queue has room
    assign in_stall = front_valid_reg && q_full;
    assign take     = in_valid && !in_stall;
    assign q_push   = front_valid_reg && !q_full;
    assign q_item   = front_item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            front_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mahd_queue.sv =====
// ----------------------------------------------------------------------------
// mahd_queue
// Small FIFO of classified headers between the front end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_queue
    import mahd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire mahd_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output mahd_item_t      head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mahd_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mahd_back.sv =====
// ----------------------------------------------------------------------------
// mahd_back
// Divides the frame numerator by the sampling rate through a reciprocal
// multiply with one correction step, and holds the result request.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_back
    import mahd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire mahd_item_t         q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    header_valid,
    output logic [BYTES_W-1:0]      frame_bytes,
    output logic [RATE_W-1:0]       sample_rate_hz,
    output logic [CHAN_W-1:0]       channel_count,
    output logic [KBPS_W-1:0]       bitrate_kbps,
    output logic [SPF_W-1:0]        samples_per_frame
);

    localparam int QD_W = QUOT_W + RATE_W;

    logic advance;

    logic              a_valid_reg;
    mahd_item_t        a_item_reg;
    logic [PROD_W-1:0] a_prod_reg;

    logic              b_valid_reg;
    mahd_item_t        b_item_reg;
    logic [QUOT_W-1:0] b_quot_reg;
    logic [QD_W-1:0]   b_qd_reg;

    logic              out_valid_reg;
    logic              header_valid_reg;
    logic [BYTES_W-1:0] frame_bytes_reg;
    logic [RATE_W-1:0]  sample_rate_reg;
    logic [CHAN_W-1:0]  channel_count_reg;
    logic [KBPS_W-1:0]  bitrate_reg;
    logic [SPF_W-1:0]   spf_reg;

    logic [QUOT_W-1:0] a_quot;
    logic [RATE_W-1:0] b_div;
    logic [QD_W-1:0]   b_rem;
    logic [QUOT_W-1:0] b_quot_fix;
    logic [QUOT_W-1:0] b_quot_pad;
    logic [BYTES_W-1:0] bytes_next;

    // Advance the whole back pipeline unless the output request is held
    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && q_valid;

    assign a_quot = a_prod_reg[PROD_W-1:RECIP_S];

    assign b_div      = RATE_BASE[b_item_reg.sidx];
    assign b_rem      = QD_W'(b_item_reg.num) - b_qd_reg;
    assign b_quot_fix = b_quot_reg + QUOT_W'(b_rem >= QD_W'(b_div));
    assign b_quot_pad = b_quot_fix + QUOT_W'(b_item_reg.pad);
    assign bytes_next = b_item_reg.layer1 ? BYTES_W'(b_quot_pad << 2) : BYTES_W'(b_quot_pad);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= q_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_item_reg        <= q_item;
            a_prod_reg        <= PROD_W'(q_item.num) * PROD_W'(RECIP_TAB[q_item.sidx]);
            b_item_reg        <= a_item_reg;
            b_quot_reg        <= a_quot;
            b_qd_reg          <= QD_W'(a_quot) * QD_W'(RATE_BASE[a_item_reg.sidx]);
            header_valid_reg  <= b_item_reg.ok;
            frame_bytes_reg   <= bytes_next;
            sample_rate_reg   <= b_item_reg.rate;
            channel_count_reg <= b_item_reg.chans;
            bitrate_reg       <= b_item_reg.kbps;
            spf_reg           <= b_item_reg.spf;
        end
    end

    assign out_valid         = out_valid_reg;
    assign header_valid      = header_valid_reg;
    assign frame_bytes       = frame_bytes_reg;
    assign sample_rate_hz    = sample_rate_reg;
    assign channel_count     = channel_count_reg;
    assign bitrate_kbps      = bitrate_reg;
    assign samples_per_frame = spf_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mpeg_audio_header_decoder.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// Decodes one 32-bit MPEG-1/2/2.5 audio frame header per request into frame
// length, sampling rate, bitrate, channel count and samples per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / header_word) carries one header per
//   request. Output channel (out_valid / out_stall / result fields) returns
//   exactly one result per header, in order.
//   Throughput: one header per cycle when out_stall is low; the front end,
//   the queue and the three-stage divider pipeline each move one request
//   per cycle. Path: the front register is loaded at the input accept edge,
//   then the request passes the queue slot, the reciprocal product, quotient
//   times rate, and the correction and output register that raises out_valid.
//   A rejected header yields all-zero fields except samples_per_frame = 1152.
//   Reset clears every valid flag and the queue; no result is pending after.
//   When the receiver stalls, the output request holds and the divider
//   pipeline freezes; the queue keeps absorbing headers until it fills, then
//   in_stall rises while the front register holds its request.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_audio_header_decoder
    import mahd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        header_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    header_valid,
    output logic [BYTES_W-1:0]      frame_bytes,
    output logic [RATE_W-1:0]       sample_rate_hz,
    output logic [CHAN_W-1:0]       channel_count,
    output logic [KBPS_W-1:0]       bitrate_kbps,
    output logic [SPF_W-1:0]        samples_per_frame
);

    // Front end to queue
    logic       q_push;
    logic       q_full;
    mahd_item_t q_push_item;

    // Queue to back end
    logic       q_pop;
    logic       q_head_valid;
    mahd_item_t q_head_item;

    // Validate, look up and form the numerator
    mahd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .header_word (header_word),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    // Decouple the front end from output backpressure
    mahd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    // Divide by the sampling rate and drive the result request
    mahd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_head_valid),
        .q_item            (q_head_item),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .header_valid      (header_valid),
        .frame_bytes       (frame_bytes),
        .sample_rate_hz    (sample_rate_hz),
        .channel_count     (channel_count),
        .bitrate_kbps      (bitrate_kbps),
        .samples_per_frame (samples_per_frame)
    );

endmodule

`default_nettype wire
